### rtl/core/fpba_pkg.sv
// Shared constants and types for the fit-policy block allocator.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package fpba_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SIZE_BITS = 16;
   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef logic [SLOT_BITS-1:0] slot_idx_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   // Command codes carried by a request word.
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // Placement policy codes; the fourth code behaves as first fit.
   localparam logic [1:0] MODE_FIRST_FIT = 2'd0;
   localparam logic [1:0] MODE_BEST_FIT  = 2'd1;
   localparam logic [1:0] MODE_WORST_FIT = 2'd2;

endpackage : fpba_pkg

`default_nettype wire

### rtl/core/fpba_channel_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on fpba_pkg for the field widths.
`default_nettype none

interface fpba_req_if
   import fpba_pkg::*;
   ();
   logic         valid;
   logic         ready;
   logic         cmd;
   slot_idx_type slot_index;
   size_type     size_value;

   modport source (output valid, output cmd, output slot_index, output size_value,
                   input ready);
   modport sink   (input valid, input cmd, input slot_index, input size_value,
                   output ready);
endinterface : fpba_req_if

interface fpba_rsp_if
   import fpba_pkg::*;
   ();
   logic         valid;
   logic         ready;
   logic         granted;
   slot_idx_type chosen_slot;

   modport source (output valid, output granted, output chosen_slot, input ready);
   modport sink   (input valid, input granted, input chosen_slot, output ready);
endinterface : fpba_rsp_if

`default_nettype wire

### rtl/core/fit_policy_block_allocator_unit.sv
// Fit-policy block allocator: size table in a synchronous memory, scanned per request.
// Depends on fpba_pkg and the channel interfaces in fpba_channel_if.sv.
//
//   channel   direction   word
//   req_ch    in          cmd, slot_index, size_value
//   rsp_ch    out         granted, chosen_slot (one word per allocation request)
//   csr_*     in          fit_mode write (csr_we, csr_wdata)
//
// A load word is accepted in the idle state and produces no response word.
// A request is accepted in idle, then scans the table with one size-memory read per slot,
// issued back to back through the single read port, and ends in the finish state.
// Reset clears the present and taken bits, the policy and the response valid bit.
// The response register lets loads and the next request proceed while a response
// waits; a request only stalls in its finish cycle if the previous response is unread.
`default_nettype none

module fit_policy_block_allocator_unit
   import fpba_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   fpba_req_if.sink   req_ch,
   fpba_rsp_if.source rsp_ch,
   input  wire        csr_we,
   input  wire  [1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           mode_ff;
   logic [1:0]           scan_mode_ff, scan_mode_in;
   size_type             want_ff, want_in;
   slot_idx_type         scan_idx_ff, scan_idx_in;
   logic                 found_ff, found_in;
   slot_idx_type         pick_ff, pick_in;
   size_type             best_ff, best_in;
   logic [NUM_SLOTS-1:0] present_ff, present_in;
   logic [NUM_SLOTS-1:0] taken_ff, taken_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   slot_idx_type         rsp_slot_ff, rsp_slot_in;

   size_type             size_mem [NUM_SLOTS];
   size_type             rd_data_ff;
   slot_idx_type         rd_addr;
   logic                 mem_we;

   logic                 accept;
   logic                 fits;
   logic                 better;
   logic                 rsp_free;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign mem_we   = accept && (req_ch.cmd == CMD_LOAD) && (int'(req_ch.slot_index) < NUM_SLOTS);

   // Read address runs one slot ahead of the slot being evaluated.
   assign rd_addr = (state_ff == ST_SCAN) ? scan_idx_ff + slot_idx_type'(1) : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[req_ch.slot_index] <= req_ch.size_value;
      end
      rd_data_ff <= size_mem[rd_addr];
   end

   assign fits = present_ff[scan_idx_ff] && !taken_ff[scan_idx_ff] && (rd_data_ff >= want_ff);

   always_comb begin
      case (scan_mode_ff)
         MODE_BEST_FIT:  better = rd_data_ff < best_ff;
         MODE_WORST_FIT: better = rd_data_ff > best_ff;
         default:        better = 1'b0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      scan_mode_in   = scan_mode_ff;
      want_in        = want_ff;
      scan_idx_in    = scan_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      present_in     = present_ff;
      taken_in       = taken_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.cmd == CMD_REQUEST) begin
                  state_in     = ST_SCAN;
                  scan_mode_in = mode_ff;
                  want_in      = req_ch.size_value;
                  scan_idx_in  = '0;
                  found_in     = 1'b0;
                  pick_in      = '0;
                  best_in      = '0;
               end else if (mem_we) begin
                  present_in[req_ch.slot_index] = 1'b1;
                  taken_in[req_ch.slot_index]   = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (fits && (!found_ff || better)) begin
               found_in = 1'b1;
               pick_in  = scan_idx_ff;
               best_in  = rd_data_ff;
            end
            if (int'(scan_idx_ff) == NUM_SLOTS - 1) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + slot_idx_type'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_slot_in    = found_ff ? pick_ff : '0;
               if (found_ff) begin
                  taken_in[pick_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FIRST_FIT;
         present_ff   <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_mode_ff   <= scan_mode_in;
      want_ff        <= want_in;
      scan_idx_ff    <= scan_idx_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.granted     = rsp_granted_ff;
   assign rsp_ch.chosen_slot = rsp_slot_ff;

endmodule : fit_policy_block_allocator_unit

`default_nettype wire
